// ===== design/bgc_pkg.sv =====
// Shared constants, state type and controller/datapath interface structs.
package bgc_pkg;

  localparam int DEF_MAX_NODES = 1024;
  localparam int DEF_MAX_EDGES = 4096;

  localparam int VERTEX_W = 10;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam int REG_IDX_W = 1;

  localparam logic [VERTEX_W-1:0] START_VERTEX_RESET = 10'd1;
  localparam logic [REG_IDX_W-1:0] REG_START_VERTEX = 1'b0;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LD_WA,
    ST_LD_RDB,
    ST_LD_WB,
    ST_W_START,
    ST_W_TOP,
    ST_W_POP,
    ST_W_ARC,
    ST_W_COL,
    ST_W_PUSH,
    ST_DONE
  } bgc_state_t;

  typedef struct packed {
    logic clear_step;
    logic accept;
    logic ld_wa;
    logic ld_rdb;
    logic ld_wb;
    logic walk_start;
    logic walk_pop;
    logic walk_arc;
    logic walk_push;
    logic walk_load_top;
    logic set_result;
    logic result_val;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic edge_ok;
    logic last;
    logic start_ok;
    logic arc_end;
    logic depth_one;
    logic stack_full;
    logic seen;
    logic same_colour;
    logic clear_last;
    logic out_busy;
  } ctrl_status_t;

endpackage

// ===== design/bgc_ctrl.sv =====
// Controller state machine: edge loading, depth-first walk and clearing sweep.
module bgc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  bgc_pkg::ctrl_status_t status,
  output bgc_pkg::ctrl_cmd_t    cmd
);
  import bgc_pkg::*;

  bgc_state_t state;
  bgc_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (status.edge_ok) begin
            state_next = ST_LD_WA;
          end else if (status.last) begin
            state_next = ST_W_START;
          end
        end
      end
      ST_LD_WA: begin
        cmd.ld_wa = 1'b1;
        state_next = ST_LD_RDB;
      end
      ST_LD_RDB: begin
        cmd.ld_rdb = 1'b1;
        state_next = ST_LD_WB;
      end
      ST_LD_WB: begin
        cmd.ld_wb = 1'b1;
        state_next = status.last ? ST_W_START : ST_IDLE;
      end
      ST_W_START: begin
        if (status.start_ok) begin
          cmd.walk_start = 1'b1;
          state_next = ST_W_PUSH;
        end else begin
          cmd.set_result = 1'b1;
          cmd.result_val = 1'b1;
          state_next = ST_DONE;
        end
      end
      ST_W_TOP: begin
        if (!status.arc_end) begin
          state_next = ST_W_ARC;
        end else if (status.depth_one) begin
          cmd.set_result = 1'b1;
          cmd.result_val = 1'b1;
          state_next = ST_DONE;
        end else begin
          state_next = ST_W_POP;
        end
      end
      ST_W_POP: begin
        cmd.walk_pop = 1'b1;
        state_next = ST_W_TOP;
      end
      ST_W_ARC: begin
        cmd.walk_arc = 1'b1;
        state_next = ST_W_COL;
      end
      ST_W_COL: begin
        if (!status.seen) begin
          if (status.stack_full) begin
            cmd.set_result = 1'b1;
            state_next = ST_DONE;
          end else begin
            cmd.walk_push = 1'b1;
            state_next = ST_W_PUSH;
          end
        end else if (status.same_colour) begin
          cmd.set_result = 1'b1;
          state_next = ST_DONE;
        end else begin
          state_next = ST_W_TOP;
        end
      end
      ST_W_PUSH: begin
        cmd.walk_load_top = 1'b1;
        state_next = ST_W_TOP;
      end
      ST_DONE: begin
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_next = ST_CLEAR;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

// ===== design/bgc_datapath.sv =====
// Datapath: adjacency, colour and stack memories, walk registers and result register.
module bgc_datapath #(
  parameter int MAX_NODES = bgc_pkg::DEF_MAX_NODES,
  parameter int MAX_EDGES = bgc_pkg::DEF_MAX_EDGES
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [bgc_pkg::VERTEX_W-1:0]  vertex_a,
  input  logic [bgc_pkg::VERTEX_W-1:0]  vertex_b,
  input  logic                          last_edge,
  input  logic [bgc_pkg::VERTEX_W-1:0]  start_vertex,
  input  bgc_pkg::ctrl_cmd_t            cmd,
  output bgc_pkg::ctrl_status_t         status,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          is_bipartite,
  output logic                          edge_overflow
);
  import bgc_pkg::*;

  localparam int NW      = $clog2(MAX_NODES);
  localparam int ARC_CAP = 2 * MAX_EDGES;
  localparam int AW      = $clog2(ARC_CAP + 1);
  localparam int ARC_AW  = $clog2(ARC_CAP);
  localparam int DW      = $clog2(MAX_NODES + 1);
  localparam logic [AW-1:0] NULL_ARC = AW'(ARC_CAP);

  // Memories
  logic [AW-1:0]      head_mem [MAX_NODES];
  logic [NW+AW-1:0]   arc_mem  [ARC_CAP];
  logic [1:0]         col_mem  [MAX_NODES];
  logic [NW+AW:0]     stk_mem  [MAX_NODES];

  logic [AW-1:0]      head_rd;
  logic [NW+AW-1:0]   arc_rd;
  logic [1:0]         col_rd;
  logic [NW+AW:0]     stk_rd;

  // Registers
  logic [NW-1:0] ea;
  logic [NW-1:0] eb;
  logic          elast;
  logic [AW-1:0] arc_count;
  logic          overflow_seen;
  logic [NW-1:0] clr_idx;
  logic [NW-1:0] u_reg;
  logic [NW-1:0] top_v;
  logic [AW-1:0] top_p;
  logic          top_c;
  logic [DW-1:0] depth;
  logic          result_bit;

  // Port controls
  logic              head_we;
  logic [NW-1:0]     head_wa;
  logic [AW-1:0]     head_wd;
  logic [NW-1:0]     head_ra;
  logic              arc_we;
  logic [ARC_AW-1:0] arc_wa;
  logic [NW+AW-1:0]  arc_wd;
  logic              col_we;
  logic [NW-1:0]     col_wa;
  logic [1:0]        col_wd;
  logic [NW-1:0]     col_ra;
  logic [NW-1:0]     stk_wa;
  logic [NW-1:0]     stk_ra;

  logic a_in_range;
  logic b_in_range;
  logic arcs_fit;
  logic [AW-1:0] arc_count_inc;

  assign a_in_range    = 32'(vertex_a) < 32'(MAX_NODES);
  assign b_in_range    = 32'(vertex_b) < 32'(MAX_NODES);
  assign arcs_fit      = (32'(arc_count) + 32'd2) <= 32'(ARC_CAP);
  assign arc_count_inc = arc_count + AW'(1);

  always_comb begin
    head_we = 1'b0;
    head_wa = clr_idx;
    head_wd = NULL_ARC;
    if (cmd.clear_step) begin
      head_we = 1'b1;
    end else if (cmd.ld_wa) begin
      head_we = 1'b1;
      head_wa = ea;
      head_wd = arc_count;
    end else if (cmd.ld_wb) begin
      head_we = 1'b1;
      head_wa = eb;
      head_wd = arc_count_inc;
    end

    if (cmd.accept) begin
      head_ra = NW'(vertex_a);
    end else if (cmd.ld_rdb) begin
      head_ra = eb;
    end else if (cmd.walk_start) begin
      head_ra = NW'(start_vertex);
    end else begin
      head_ra = u_reg;
    end

    arc_we = cmd.ld_wa | cmd.ld_wb;
    if (cmd.ld_wb) begin
      arc_wa = ARC_AW'(arc_count_inc);
      arc_wd = {ea, head_rd};
    end else begin
      arc_wa = ARC_AW'(arc_count);
      arc_wd = {eb, head_rd};
    end

    col_we = 1'b0;
    col_wa = clr_idx;
    col_wd = 2'b00;
    if (cmd.clear_step) begin
      col_we = 1'b1;
    end else if (cmd.walk_start) begin
      col_we = 1'b1;
      col_wa = NW'(start_vertex);
      col_wd = 2'b10;
    end else if (cmd.walk_push) begin
      col_we = 1'b1;
      col_wa = u_reg;
      col_wd = {1'b1, ~top_c};
    end
    col_ra = arc_rd[NW+AW-1:AW];

    stk_wa = NW'(depth - DW'(1));
    stk_ra = NW'(depth - DW'(2));
  end

  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[head_wa] <= head_wd;
    end
    head_rd <= head_mem[head_ra];
  end

  always_ff @(posedge clk) begin
    if (arc_we) begin
      arc_mem[arc_wa] <= arc_wd;
    end
    arc_rd <= arc_mem[top_p[ARC_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (col_we) begin
      col_mem[col_wa] <= col_wd;
    end
    col_rd <= col_mem[col_ra];
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_push) begin
      stk_mem[stk_wa] <= {top_v, top_p, top_c};
    end
    stk_rd <= stk_mem[stk_ra];
  end

  // Control state: graph fill level, overflow flag, sweep index, output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      arc_count     <= '0;
      overflow_seen <= 1'b0;
      clr_idx       <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cmd.clear_step) begin
        arc_count     <= '0;
        overflow_seen <= 1'b0;
        clr_idx       <= status.clear_last ? '0 : clr_idx + NW'(1);
      end else begin
        if (cmd.accept && a_in_range && b_in_range && !arcs_fit) begin
          overflow_seen <= 1'b1;
        end
        if (cmd.ld_wb) begin
          arc_count <= arc_count + AW'(2);
        end
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Edge, walk, result and output registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ea    <= NW'(vertex_a);
      eb    <= NW'(vertex_b);
      elast <= last_edge;
    end
    if (cmd.walk_start) begin
      u_reg <= NW'(start_vertex);
      top_c <= 1'b1;
      depth <= '0;
    end else if (cmd.walk_arc) begin
      u_reg <= arc_rd[NW+AW-1:AW];
      top_p <= arc_rd[AW-1:0];
    end else if (cmd.walk_load_top) begin
      top_v <= u_reg;
      top_p <= head_rd;
      top_c <= ~top_c;
      depth <= depth + DW'(1);
    end else if (cmd.walk_pop) begin
      {top_v, top_p, top_c} <= stk_rd;
      depth <= depth - DW'(1);
    end
    if (cmd.set_result) begin
      result_bit <= cmd.result_val;
    end
    if (cmd.out_load) begin
      is_bipartite  <= result_bit;
      edge_overflow <= overflow_seen;
    end
  end

  always_comb begin
    status.edge_ok     = a_in_range && b_in_range && arcs_fit;
    status.last        = cmd.accept ? last_edge : elast;
    status.start_ok    = 32'(start_vertex) < 32'(MAX_NODES);
    status.arc_end     = top_p >= arc_count;
    status.depth_one   = depth == DW'(1);
    status.stack_full  = 32'(depth) >= 32'(MAX_NODES);
    status.seen        = col_rd[1];
    status.same_colour = col_rd[0] == top_c;
    status.clear_last  = clr_idx == NW'(MAX_NODES - 1);
    status.out_busy    = out_valid && !out_ready;
  end

endmodule

// ===== design/bipartite_graph_check.sv =====
// Top level of the bipartite graph check: configuration register, controller and datapath.
//
// Edges enter on the input channel (vertex_a, vertex_b, last_edge) by valid/ready
// transfers. Each in-range edge is stored in both directions in per-vertex arc
// lists; an edge that does not fit sets the overflow flag and is dropped, and an
// edge with an endpoint outside the vertex range is dropped silently.
// A stored edge passes ST_IDLE, ST_LD_WA, ST_LD_RDB and ST_LD_WB (one head read and write
// per arc on the head memory); a dropped edge is taken in ST_IDLE alone.
// The transfer that carries last_edge starts a depth-first two-colouring walk
// from the start_vertex register, using a stack memory. The walk begins in ST_W_START and
// ST_W_PUSH, takes ST_W_TOP, ST_W_ARC and ST_W_COL per arc examined, ST_W_PUSH per new
// vertex and ST_W_POP and ST_W_TOP per pop, so its run time grows with the start component.
// One result transfer (is_bipartite, edge_overflow) follows each last edge. It sits
// in an output register until the receiver takes it; a stalled receiver holds the
// block in its final state once the next result is ready, but does not lose the result.
// After each result, and after reset, a clearing sweep rewrites the list heads and
// the visited marks, one vertex per cycle, and in_ready is low until it ends.
// Configuration writes are taken at any time on the APB port.
// Reset is synchronous and sets start_vertex to one.
module bipartite_graph_check #(
  parameter int MAX_NODES = bgc_pkg::DEF_MAX_NODES,
  parameter int MAX_EDGES = bgc_pkg::DEF_MAX_EDGES
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [bgc_pkg::VERTEX_W-1:0]    vertex_a,
  input  logic [bgc_pkg::VERTEX_W-1:0]    vertex_b,
  input  logic                            last_edge,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            is_bipartite,
  output logic                            edge_overflow,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bgc_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [bgc_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [bgc_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import bgc_pkg::*;

  logic [VERTEX_W-1:0]  start_vertex;
  logic [REG_IDX_W-1:0] reg_idx;
  ctrl_cmd_t            cmd;
  ctrl_status_t         status;

  // Registers are word aligned, so the index is the address above the byte bits.
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_vertex <= START_VERTEX_RESET;
    end else if (psel && penable && pwrite && (reg_idx == REG_START_VERTEX)) begin
      start_vertex <= pwdata[VERTEX_W-1:0];
    end
  end

  // Reads of unused addresses return zero.
  always_comb begin
    if (reg_idx == REG_START_VERTEX) begin
      prdata = APB_DATA_W'(start_vertex);
    end else begin
      prdata = '0;
    end
  end

  bgc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  bgc_datapath #(
    .MAX_NODES (MAX_NODES),
    .MAX_EDGES (MAX_EDGES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .vertex_a      (vertex_a),
    .vertex_b      (vertex_b),
    .last_edge     (last_edge),
    .start_vertex  (start_vertex),
    .cmd           (cmd),
    .status        (status),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .is_bipartite  (is_bipartite),
    .edge_overflow (edge_overflow)
  );

endmodule

// ===== design/bgc_checker.sv =====
// Port-level checker for the bipartite graph check, bound to the top level.
module bgc_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic last_edge,
  input logic out_valid,
  input logic out_ready,
  input logic is_bipartite,
  input logic edge_overflow
);

  // A result that is not taken stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(is_bipartite) && $stable(edge_overflow))
    else $error("result changed or vanished while stalled");

  // Reset starts the clearing sweep, so no edge is taken straight after it.
  a_reset_sweep: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("input ready directly after reset");

  // A new result is always followed by the clearing sweep.
  a_result_sweep: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !in_ready)
    else $error("input ready while a new result appears");

  // The final edge of a graph hands the block over to the walk.
  a_last_walk: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && last_edge |=> !in_ready)
    else $error("input ready directly after the final edge");

endmodule

bind bipartite_graph_check bgc_checker u_bgc_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .last_edge     (last_edge),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .is_bipartite  (is_bipartite),
  .edge_overflow (edge_overflow)
);
